@@ rtl/beacon_csa_element_scanner_core_assert.svh @@
// Assertion macros for the channel switch element scanner.
// Used by the top level only; expects clk_i and rst_ni in scope.
`ifndef BEACON_CSA_ELEMENT_SCANNER_CORE_ASSERT_SVH
`define BEACON_CSA_ELEMENT_SCANNER_CORE_ASSERT_SVH

// Same-cycle implication, checked out of reset
`define BCSA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Delayed implication, checked out of reset
`define BCSA_ASSERT_LATER(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> ##1 (cons)) \
    else $error(msg);

`endif

@@ rtl/bcsa_pkg.sv @@
// Shared constants and types for the channel switch element scanner.
// No dependencies; used by every module of the block.
package bcsa_pkg;

  // Frame layout constants
  localparam logic [7:0]  CsaElementId    = 8'h25;
  localparam logic [16:0] MacHeaderBytes  = 17'd24;
  localparam logic [16:0] FixedFieldBytes = 17'd12;
  localparam logic [16:0] FcsBytes        = 17'd4;
  localparam logic [16:0] ElemHeadBytes   = 17'd2;
  localparam logic [16:0] ChanOffset      = 17'd3;
  localparam logic [7:0]  BeaconFc        = 8'h80;
  localparam logic [15:0] ClearedBytePos  = 16'd16;
  localparam logic [7:0]  ClearedByteVal  = 8'h00;
  localparam logic [15:0] RtLenLoPos      = 16'd2;
  localparam logic [15:0] RtLenHiPos      = 16'd3;
  localparam logic [15:0] FirstFcPos      = 16'd4;
  localparam logic [15:0] WalkStartPos    = 16'd36;
  localparam logic [15:0] PosMax          = 16'hFFFF;

  // Queue between front and back
  localparam int unsigned QDepth = 4;
  localparam int unsigned QAw    = $clog2(QDepth);
  localparam int unsigned QCw    = $clog2(QDepth + 1);

  // Configuration register indexes
  typedef enum logic [0:0] {
    REG_REPL_CHAN = 1'b0,
    REG_REWRITE   = 1'b1
  } cfg_reg_e;

  // Classified byte handed from front to back
  typedef struct packed {
    logic [7:0] data;
    logic       keep;
    logic       last;
    logic       capture;  // byte is the channel byte of the hit element
    logic       clear;    // byte sits at the cleared position
    logic       beacon;   // frame flags as seen after this byte
    logic       hit;
  } rec_t;

endpackage

@@ rtl/beacon_csa_element_scanner_core.sv @@
// Top level of the channel switch element scanner: configuration registers,
// front end, queue and back end. Depends on bcsa_pkg, the assertion header and the front, queue and back modules.
//
//   channel  handshake          payload
//   input    push / full        data_byte_i, capture_length_i, frame_end_i
//   result   empty / pop        out_byte_o .. csa_channel_o
//   config   cfg_we_i           cfg_idx_i, cfg_data_i
//
// One result per byte; a byte is taken every cycle while the queue has room.
// From push to a result on the ports a byte passes through the front end into
// the queue, then into the output register of the back end.
// full rises only when four bytes wait behind a stalled result.
// Reset clears the frame state, the queue and the registers; no sweep.
module beacon_csa_element_scanner_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  data_byte_i,
  input  logic [15:0] capture_length_i,
  input  logic        frame_end_i,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  out_byte_o,
  output logic        keep_byte_o,
  output logic        result_end_o,
  output logic        is_beacon_o,
  output logic        csa_found_o,
  output logic [7:0]  csa_channel_o,
  input  logic        cfg_we_i,
  input  logic [0:0]  cfg_idx_i,
  input  logic [7:0]  cfg_data_i
);

  `include "beacon_csa_element_scanner_core_assert.svh"

  logic                        accept;
  logic                        q_take;
  logic                        q_valid;
  logic                        out_valid;
  logic [bcsa_pkg::QCw-1:0]    q_count;
  bcsa_pkg::rec_t              front_rec;
  bcsa_pkg::rec_t              back_rec;
  logic [7:0]                  repl_chan_q;
  logic                        rewrite_en_q;

  assign accept = push && !full;
  assign empty  = !out_valid;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      repl_chan_q  <= '0;
      rewrite_en_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (bcsa_pkg::cfg_reg_e'(cfg_idx_i))
        bcsa_pkg::REG_REPL_CHAN: repl_chan_q  <= cfg_data_i;
        bcsa_pkg::REG_REWRITE:   rewrite_en_q <= cfg_data_i[0];
        default:                 repl_chan_q  <= repl_chan_q;
      endcase
    end
  end

  bcsa_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .accept_i         (accept),
    .data_byte_i      (data_byte_i),
    .capture_length_i (capture_length_i),
    .frame_end_i      (frame_end_i),
    .rec_o            (front_rec)
  );

  bcsa_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (accept),
    .wr_data_i (front_rec),
    .rd_i      (q_take),
    .rd_data_o (back_rec),
    .full_o    (full),
    .valid_o   (q_valid),
    .count_o   (q_count)
  );

  bcsa_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .rec_valid_i   (q_valid),
    .rec_i         (back_rec),
    .rec_take_o    (q_take),
    .repl_chan_i   (repl_chan_q),
    .rewrite_en_i  (rewrite_en_q),
    .pop_i         (pop),
    .out_valid_o   (out_valid),
    .out_byte_o    (out_byte_o),
    .keep_byte_o   (keep_byte_o),
    .result_end_o  (result_end_o),
    .is_beacon_o   (is_beacon_o),
    .csa_found_o   (csa_found_o),
    .csa_channel_o (csa_channel_o)
  );

  // A byte pushed into an idle block reaches the result ports through the queue and the output register
  `BCSA_ASSERT_LATER(a_idle_latency, accept && empty && (q_count == '0), !empty, "byte lost in idle pipe")

  // A found element implies a beacon and the last byte
  `BCSA_ASSERT_NOW(a_found_beacon, !empty && csa_found_o, is_beacon_o && result_end_o, "found without beacon end")

  // Report fields stay zero away from the last byte
  `BCSA_ASSERT_NOW(a_report_zero, !empty && !result_end_o, !is_beacon_o && !csa_found_o && (csa_channel_o == 8'd0), "report outside frame end")

endmodule

@@ rtl/bcsa_front.sv @@
// Front end: tracks byte position, radiotap length and the element walk,
// and classifies each accepted byte. Depends on bcsa_pkg.
module bcsa_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  logic [7:0]        data_byte_i,
  input  logic [15:0]       capture_length_i,
  input  logic              frame_end_i,
  output bcsa_pkg::rec_t    rec_o
);

  logic [15:0] pos_q, pos_d;
  logic [15:0] rtlen_q, rtlen_d;
  logic [15:0] nxt_q, nxt_d;
  logic [15:0] hpos_q, hpos_d;
  logic        walk_q, walk_d;
  logic        hit_q, hit_d;
  logic        beacon_q, beacon_d;
  logic        in_region;
  logic        chan_byte;
  logic [16:0] first_pos;
  logic [16:0] nx_pos;

  // Parse the current byte against the frame state
  always_comb begin
    rtlen_d  = rtlen_q;
    nxt_d    = nxt_q;
    hpos_d   = hpos_q;
    walk_d   = walk_q;
    hit_d    = hit_q;
    beacon_d = beacon_q;
    first_pos = {1'b0, data_byte_i, rtlen_q[7:0]} + bcsa_pkg::MacHeaderBytes
                + bcsa_pkg::FixedFieldBytes;
    nx_pos    = {1'b0, hpos_q} + bcsa_pkg::ElemHeadBytes + {9'd0, data_byte_i};
    in_region = ({1'b0, pos_q} + bcsa_pkg::FcsBytes) < {1'b0, capture_length_i};

    // Radiotap length, little endian, then the first element position
    if (pos_q == bcsa_pkg::RtLenLoPos) begin
      rtlen_d = {8'd0, data_byte_i};
    end else if (pos_q == bcsa_pkg::RtLenHiPos) begin
      rtlen_d = {data_byte_i, rtlen_q[7:0]};
      if (first_pos[16]) begin
        walk_d = 1'b1;
      end else begin
        nxt_d = first_pos[15:0];
      end
    end

    // Frame control byte
    if (pos_q >= bcsa_pkg::FirstFcPos && pos_q == rtlen_q) begin
      beacon_d = (data_byte_i == bcsa_pkg::BeaconFc);
    end

    // Element walk: element id at the start, length one byte later
    if (pos_q >= bcsa_pkg::WalkStartPos && !walk_q && !hit_q) begin
      if (pos_q == nxt_q) begin
        if (in_region) begin
          hpos_d = pos_q;
          if (data_byte_i == bcsa_pkg::CsaElementId) begin
            hit_d = 1'b1;
          end
        end else begin
          walk_d = 1'b1;
        end
      end else if (nxt_q == hpos_q && {1'b0, pos_q} == {1'b0, hpos_q} + 17'd1) begin
        if (nx_pos[16]) begin
          walk_d = 1'b1;
        end else begin
          nxt_d = nx_pos[15:0];
        end
      end
    end

    chan_byte = hit_q && ({1'b0, pos_q} == {1'b0, hpos_q} + bcsa_pkg::ChanOffset);

    // Advance the position, saturating
    pos_d = (pos_q < bcsa_pkg::PosMax) ? pos_q + 16'd1 : pos_q;
  end

  // Classified record for the queue
  always_comb begin
    rec_o.data    = data_byte_i;
    rec_o.keep    = in_region;
    rec_o.last    = frame_end_i;
    rec_o.capture = chan_byte;
    rec_o.clear   = (pos_q == bcsa_pkg::ClearedBytePos);
    rec_o.beacon  = beacon_d;
    rec_o.hit     = hit_d;
  end

  // Frame state; cleared after the last byte of a frame
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      rtlen_q  <= '0;
      nxt_q    <= '0;
      hpos_q   <= '0;
      walk_q   <= 1'b0;
      hit_q    <= 1'b0;
      beacon_q <= 1'b0;
    end else if (accept_i) begin
      if (frame_end_i) begin
        pos_q    <= '0;
        rtlen_q  <= '0;
        nxt_q    <= '0;
        hpos_q   <= '0;
        walk_q   <= 1'b0;
        hit_q    <= 1'b0;
        beacon_q <= 1'b0;
      end else begin
        pos_q    <= pos_d;
        rtlen_q  <= rtlen_d;
        nxt_q    <= nxt_d;
        hpos_q   <= hpos_d;
        walk_q   <= walk_d;
        hit_q    <= hit_d;
        beacon_q <= beacon_d;
      end
    end
  end

endmodule

@@ rtl/bcsa_queue.sv @@
// Short queue of classified bytes between front and back.
// Depends on bcsa_pkg for the record type and depth.
module bcsa_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           wr_i,
  input  bcsa_pkg::rec_t wr_data_i,
  input  logic           rd_i,
  output bcsa_pkg::rec_t rd_data_o,
  output logic           full_o,
  output logic           valid_o,
  output logic [bcsa_pkg::QCw-1:0] count_o
);

  bcsa_pkg::rec_t                 mem_q [bcsa_pkg::QDepth];
  logic [bcsa_pkg::QAw-1:0]       wptr_q;
  logic [bcsa_pkg::QAw-1:0]       rptr_q;
  logic [bcsa_pkg::QCw-1:0]       cnt_q;
  logic                           do_wr;
  logic                           do_rd;

  assign full_o    = (cnt_q == bcsa_pkg::QCw'(bcsa_pkg::QDepth));
  assign valid_o   = (cnt_q != '0);
  assign count_o   = cnt_q;
  assign do_wr     = wr_i && !full_o;
  assign do_rd     = rd_i && valid_o;
  assign rd_data_o = mem_q[rptr_q];

  // Store entries
  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wptr_q] <= wr_data_i;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_wr) begin
        wptr_q <= wptr_q + 1'b1;
      end
      if (do_rd) begin
        rptr_q <= rptr_q + 1'b1;
      end
      case ({do_wr, do_rd})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

@@ rtl/bcsa_back.sv @@
// Back end: applies the rewrite, keeps the found channel and builds the
// end-of-frame report in an output register. Depends on bcsa_pkg.
module bcsa_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           rec_valid_i,
  input  bcsa_pkg::rec_t rec_i,
  output logic           rec_take_o,
  input  logic [7:0]     repl_chan_i,
  input  logic           rewrite_en_i,
  input  logic           pop_i,
  output logic           out_valid_o,
  output logic [7:0]     out_byte_o,
  output logic           keep_byte_o,
  output logic           result_end_o,
  output logic           is_beacon_o,
  output logic           csa_found_o,
  output logic [7:0]     csa_channel_o
);

  logic       valid_q;
  logic [7:0] chan_q;
  logic [7:0] chan_now;
  logic [7:0] byte_d;
  logic       found_d;
  logic [7:0] byte_q;
  logic       keep_q;
  logic       end_q;
  logic       beacon_q;
  logic       found_q;
  logic [7:0] chan_out_q;

  // Take the next record whenever the output register frees up
  assign rec_take_o = rec_valid_i && (!valid_q || pop_i);

  // Rewrite and report
  always_comb begin
    chan_now = rec_i.capture ? rec_i.data : chan_q;
    byte_d   = rec_i.data;
    if (rewrite_en_i) begin
      if (rec_i.clear) begin
        byte_d = bcsa_pkg::ClearedByteVal;
      end else if (rec_i.capture) begin
        byte_d = repl_chan_i;
      end
    end
    found_d = rec_i.last && rec_i.beacon && rec_i.hit;
  end

  // Output valid and the channel kept across a frame
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      chan_q  <= '0;
    end else begin
      if (rec_take_o) begin
        valid_q <= 1'b1;
        chan_q  <= rec_i.last ? 8'd0 : chan_now;
      end else if (pop_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  // Output payload
  always_ff @(posedge clk_i) begin
    if (rec_take_o) begin
      byte_q     <= byte_d;
      keep_q     <= rec_i.keep;
      end_q      <= rec_i.last;
      beacon_q   <= rec_i.last && rec_i.beacon;
      found_q    <= found_d;
      chan_out_q <= found_d ? chan_now : 8'd0;
    end
  end

  assign out_valid_o   = valid_q;
  assign out_byte_o    = byte_q;
  assign keep_byte_o   = keep_q;
  assign result_end_o  = end_q;
  assign is_beacon_o   = beacon_q;
  assign csa_found_o   = found_q;
  assign csa_channel_o = chan_out_q;

endmodule
